// ===== design/srdz_pkg.sv =====
// ----------------------------------------------------------------------------
// srdz_pkg - shared types for the stick radial deadzone block
// sequencer state codes and configuration register indexes
// ----------------------------------------------------------------------------
package srdz_pkg;

  // one-hot sequencer states
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SQX   = 14'b00000000000010,
    S_SQY   = 14'b00000000000100,
    S_SUM   = 14'b00000000001000,
    S_ROOT  = 14'b00000000010000,
    S_CHK   = 14'b00000000100000,
    S_CLAMP = 14'b00000001000000,
    S_MAG   = 14'b00000010000000,
    S_DIVM  = 14'b00000100000000,
    S_MULX  = 14'b00001000000000,
    S_DIVX  = 14'b00010000000000,
    S_MULY  = 14'b00100000000000,
    S_DIVY  = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  localparam int CFG_IDX_BITS = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X     = 2'd0,
    CFG_CENTER_Y     = 2'd1,
    CFG_INNER_RADIUS = 2'd2,
    CFG_RADIUS_RANGE = 2'd3
  } cfg_idx_t;

endpackage

// ===== design/stick_radial_deadzone.sv =====
// ----------------------------------------------------------------------------
// stick_radial_deadzone - radial deadzone and ring rescaling for one stick
// subtracts the center, takes the integer distance, applies the deadzone and
// rescales both offsets across the live ring, keeping the direction
// ----------------------------------------------------------------------------
//
//  channel  ports                                  handshake
//  -------  -------------------------------------  ---------------------------
//  input    in_x_sample, in_y_sample               start high while busy low
//  result   out_x_out, out_y_out                   out_valid, one-cycle strobe
//  config   cfg_index, cfg_data                    cfg_valid and cfg_ready
//
//  - the bit-serial root and the three long divisions all run on one
//    shared subtract/compare unit
//  - a sample inside the deadzone skips the divisions
//  - busy is high from the accepting edge until the strobe is raised
//  - synchronous active-low reset restores the default calibration
//  - the receiver cannot stall; the result is shown for exactly one cycle
//  - cfg_ready is always high; writes are meant for idle periods only
//
module stick_radial_deadzone
  import srdz_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  logic [SAMPLE_BITS-1:0]  in_x_sample,
  input  logic [SAMPLE_BITS-1:0]  in_y_sample,
  // result channel
  output logic                    out_valid,
  output logic [SAMPLE_BITS-1:0]  out_x_out,
  output logic [SAMPLE_BITS-1:0]  out_y_out,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]  cfg_data
);

  localparam int W     = SAMPLE_BITS;
  localparam int PW    = 2 * W;       // product and dividend width
  localparam int NB    = 2 * W + 2;   // radicand width, even
  localparam int UW    = W + 4;       // shared subtractor width
  localparam int CNT_W = $clog2(2 * W);

  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(W);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(2 * W - 1);

  localparam logic [W-1:0] OUT_CENTER = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] OUT_MAG    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAMPLE_MAX = {W{1'b1}};
  localparam logic [W-1:0] ONE_W      = {{(W-1){1'b0}}, 1'b1};

  // calibration registers
  logic [W-1:0] center_x_r, center_y_r, inner_r, range_r;

  // sequencer and datapath registers
  state_t        state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]  ax_r, ay_r;       // offset magnitudes
  logic          nx_r, ny_r;       // offset signs
  logic [NB-1:0] acc_r;            // sum of squares, shifted out two bits a step
  logic [W:0]    root_r;           // distance
  logic [W+1:0]  rem_r;            // partial remainder, root and divide
  logic [PW-1:0] quo_r;            // dividend in, quotient out
  logic [W:0]    div_r;            // divisor
  logic [W:0]    excess_r;         // distance beyond the inner radius
  logic [W-1:0]  num_r;            // clamped ring position
  logic [W-1:0]  m_r;              // output magnitude
  logic [W-1:0]  mx_r;             // scaled x magnitude
  logic          out_valid_r;
  logic [W-1:0]  out_x_r, out_y_r;

  // shared multiplier, registered into quo_r
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] mul_p;

  // shared subtract/compare unit
  logic [UW-1:0] alu_a, alu_b;
  logic [UW:0]   alu_diff;
  logic          alu_ge;

  logic [W-1:0]  range_eff;
  logic          is_root, is_div;

  // ring width of zero acts as one
  assign range_eff = (range_r == '0) ? ONE_W : range_r;

  assign is_root = (state_r == S_ROOT);
  assign is_div  = (state_r == S_DIVM) || (state_r == S_DIVX) || (state_r == S_DIVY);

  // operand select for the multiplier
  always_comb begin
    mul_a = ax_r;
    mul_b = ax_r;
    unique case (state_r)
      S_SQY: begin
        mul_a = ay_r;
        mul_b = ay_r;
      end
      S_MAG: begin
        mul_a = num_r;
        mul_b = OUT_MAG;
      end
      S_MULX: begin
        mul_a = ax_r;
        mul_b = quo_r[W-1:0];
      end
      S_MULY: begin
        mul_a = ay_r;
        mul_b = m_r;
      end
      default: begin
        mul_a = ax_r;
        mul_b = ax_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // root step: trial 4*root+1 against remainder with next bit pair
  // divide step: divisor against remainder with next dividend bit
  always_comb begin
    if (is_root) begin
      alu_a = {rem_r, acc_r[NB-1 -: 2]};
      alu_b = {1'b0, root_r, 2'b01};
    end else begin
      alu_a = {2'b00, rem_r[W:0], quo_r[PW-1]};
      alu_b = {3'b000, div_r};
    end
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[UW];

  // re-center with saturation to the sample range
  function automatic logic [W-1:0] place_fn(input logic [W-1:0] mag, input logic neg);
    logic [W:0] sum;
    sum = {1'b0, OUT_CENTER} + {1'b0, mag};
    if (neg && (mag != '0)) begin
      place_fn = (mag >= OUT_CENTER) ? '0 : OUT_CENTER - mag;
    end else begin
      place_fn = (sum > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : sum[W-1:0];
    end
  endfunction

  // calibration writes, taken at any time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= OUT_CENTER;
      center_y_r <= OUT_CENTER;
      inner_r    <= '0;
      range_r    <= OUT_MAG;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X:     center_x_r <= cfg_data;
        CFG_CENTER_Y:     center_y_r <= cfg_data;
        CFG_INNER_RADIUS: inner_r    <= cfg_data;
        CFG_RADIUS_RANGE: range_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE:  if (start) state_r <= S_SQX;
        S_SQX:   state_r <= S_SQY;
        S_SQY:   state_r <= S_SUM;
        S_SUM: begin
          state_r <= S_ROOT;
          cnt_r   <= '0;
        end
        S_ROOT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == ROOT_LAST) state_r <= S_CHK;
        end
        S_CHK:   state_r <= (root_r <= {1'b0, inner_r}) ? S_FIN : S_CLAMP;
        S_CLAMP: state_r <= S_MAG;
        S_MAG: begin
          state_r <= S_DIVM;
          cnt_r   <= '0;
        end
        S_DIVM: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) state_r <= S_MULX;
        end
        S_MULX: begin
          state_r <= S_DIVX;
          cnt_r   <= '0;
        end
        S_DIVX: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) state_r <= S_MULY;
        end
        S_MULY: begin
          state_r <= S_DIVY;
          cnt_r   <= '0;
        end
        S_DIVY: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) state_r <= S_FIN;
        end
        S_FIN: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        // offsets as sign and magnitude
        nx_r <= (in_x_sample < center_x_r);
        ny_r <= (in_y_sample < center_y_r);
        ax_r <= (in_x_sample < center_x_r) ? center_x_r - in_x_sample
                                            : in_x_sample - center_x_r;
        ay_r <= (in_y_sample < center_y_r) ? center_y_r - in_y_sample
                                            : in_y_sample - center_y_r;
      end
      S_SQX:  quo_r <= mul_p;
      S_SQY: begin
        acc_r <= {2'b00, quo_r};
        quo_r <= mul_p;
      end
      S_SUM: begin
        acc_r  <= acc_r + {2'b00, quo_r};
        rem_r  <= '0;
        root_r <= '0;
      end
      S_ROOT: begin
        rem_r  <= alu_ge ? alu_diff[W+1:0] : alu_a[W+1:0];
        root_r <= {root_r[W-1:0], alu_ge};
        acc_r  <= {acc_r[NB-3:0], 2'b00};
      end
      S_CHK: begin
        // inside the deadzone both magnitudes are zero
        mx_r     <= '0;
        quo_r    <= '0;
        excess_r <= root_r - {1'b0, inner_r};
      end
      S_CLAMP: num_r <= (excess_r > {1'b0, range_eff}) ? range_eff : excess_r[W-1:0];
      S_MAG: begin
        quo_r <= mul_p;
        rem_r <= '0;
        div_r <= {1'b0, range_eff};
      end
      S_MULX: begin
        m_r   <= quo_r[W-1:0];
        quo_r <= mul_p;
        rem_r <= '0;
        div_r <= root_r;
      end
      S_MULY: begin
        mx_r  <= quo_r[W-1:0];
        quo_r <= mul_p;
        rem_r <= '0;
      end
      S_DIVM, S_DIVX, S_DIVY: begin
        rem_r <= alu_ge ? alu_diff[W+1:0] : alu_a[W+1:0];
        quo_r <= {quo_r[PW-2:0], alu_ge};
      end
      S_FIN: begin
        out_x_r <= place_fn(mx_r, nx_r);
        out_y_r <= place_fn(quo_r[W-1:0], ny_r);
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_x_out = out_x_r;
  assign out_y_out = out_y_r;

  // the strobe only follows the final sequencer step
  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FIN))
    else $error("result strobe without a finished request");

  // an accepted request makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not start the sequencer");

  // the block only goes idle by delivering a result
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("request dropped without a result");

  // zero magnitude on x gives the centered output
  a_center_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mx_r == '0) |-> out_x_out == OUT_CENTER)
    else $error("zero x magnitude not centered");

  // during the root and divider iterations the counter stays in range and the two never overlap
  a_alu_use: assert property (@(posedge clk) disable iff (!rst_n)
    (is_root || is_div) |-> (cnt_r <= DIV_LAST) && !(is_root && is_div))
    else $error("iteration counter out of range");

endmodule
